@@ rtl/core/first_fit_coalescing_allocator_top_assert.svh @@
// Assertion macros for the allocator top level.
`ifndef FIRST_FIT_COALESCING_ALLOCATOR_TOP_ASSERT_SVH
`define FIRST_FIT_COALESCING_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define FFCA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FFCA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/ffca_pkg.sv @@
package ffca_pkg;

  localparam int MAX_IDS_DEF = 64;

  // Configuration register indexes (paddr[2])
  localparam logic REG_CAPACITY = 1'b0;
  localparam logic REG_ALIGN    = 1'b1;

  localparam logic [31:0] CAPACITY_RST = 32'd65536;
  localparam logic [4:0]  ALIGN_RST    = 5'd8;

  // Request kinds
  localparam logic [1:0] K_RESERVE = 2'd0;
  localparam logic [1:0] K_FREE    = 2'd1;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_IN_USE    = 2'd1;
  localparam logic [1:0] ST_NO_FIT    = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  // Free-list write data selects
  localparam logic [2:0] WS_INIT   = 3'd0;
  localparam logic [2:0] WS_SPLIT  = 3'd1;
  localparam logic [2:0] WS_COPY   = 3'd2;
  localparam logic [2:0] WS_BEFORE = 3'd3;
  localparam logic [2:0] WS_BOTH   = 3'd4;
  localparam logic [2:0] WS_AFTER  = 3'd5;
  localparam logic [2:0] WS_INS    = 3'd6;

  typedef struct packed {
    logic       fm_re;
    logic       fm_we;
    logic [2:0] wsel;
    logic       ld_item;
    logic       id_we;
    logic       vld_clr;
    logic       used_add;
    logic       used_sub;
    logic       ld_rel;
    logic       acc_ld;
    logic       ld_prev;
    logic       ld_cur;
    logic       clr_pc;
    logic       res_clr;
    logic       res_id;
    logic       res_rsv;
    logic       out_ld;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       in_range;
    logic       id_used;
    logic       cap_ovf;
    logic       hit;
    logic       cur_gt;
    logic       q_lt_o;
    logic       after;
    logic       prev_abut;
  } sts_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

@@ rtl/core/ffca_ctrl.sv @@
module ffca_ctrl #(
  parameter int MaxIds = 64,
  parameter int Aw = 7,
  parameter int Cw = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  logic             cap_wr,
  input  ffca_pkg::sts_t   sts,
  output ffca_pkg::cmd_t   cmd,
  output logic [Aw-1:0]    fm_raddr,
  output logic [Aw-1:0]    fm_waddr,
  output logic [1:0]       st_code
);
  import ffca_pkg::*;

  localparam int Depth = MaxIds + 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_RSCAN = 4'd2;
  localparam logic [3:0] S_RSPL  = 4'd3;
  localparam logic [3:0] S_SHDN  = 4'd4;
  localparam logic [3:0] S_FSCAN = 4'd5;
  localparam logic [3:0] S_FDEC  = 4'd6;
  localparam logic [3:0] S_FBOTH = 4'd7;
  localparam logic [3:0] S_SHUP  = 4'd8;
  localparam logic [3:0] S_INS   = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  logic [3:0]    state_r, state_nxt;
  logic [Aw-1:0] ra_r, ra_nxt;
  logic [Cw-1:0] j_r, j_nxt;
  logic [Cw-1:0] count_r, count_nxt;
  logic [1:0]    st_r, st_nxt;
  logic          pend_r, pend_nxt;
  logic          ov_r, ov_nxt;
  logic [Cw-1:0] ra_inc;

  assign ra_inc    = Cw'(ra_r) + Cw'(1);
  assign in_ready  = (state_r == S_IDLE) && !pend_r;
  assign out_valid = ov_r;
  assign st_code   = st_r;

  // Sequence one request through scan, split, merge and shift steps
  always_comb begin
    cmd       = '0;
    fm_raddr  = ra_r;
    fm_waddr  = '0;
    state_nxt = state_r;
    ra_nxt    = ra_r;
    j_nxt     = j_r;
    count_nxt = count_r;
    st_nxt    = st_r;
    pend_nxt  = pend_r;
    ov_nxt    = ov_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (pend_r) begin
          cmd.fm_we = 1'b1;
          cmd.wsel  = WS_INIT;
          count_nxt = Cw'(1);
          pend_nxt  = 1'b0;
        end else if (in_valid) begin
          cmd.ld_item = 1'b1;
          state_nxt   = S_DISP;
        end
      end
      S_DISP: begin
        cmd.res_clr = 1'b1;
        cmd.clr_pc  = 1'b1;
        ra_nxt      = '0;
        fm_raddr    = '0;
        if (sts.kind == K_RESERVE) begin
          if (!sts.in_range) begin
            st_nxt = ST_NO_FIT; state_nxt = S_DONE;
          end else if (sts.id_used) begin
            st_nxt = ST_IN_USE; state_nxt = S_DONE;
          end else if (sts.cap_ovf || count_r == '0) begin
            st_nxt = ST_NO_FIT; state_nxt = S_DONE;
          end else begin
            cmd.fm_re = 1'b1;
            state_nxt = S_RSCAN;
          end
        end else if (!sts.in_range || !sts.id_used) begin
          st_nxt = ST_NOT_FOUND; state_nxt = S_DONE;
        end else begin
          st_nxt     = ST_OK;
          cmd.res_id = 1'b1;
          if (sts.kind == K_FREE) begin
            cmd.vld_clr  = 1'b1;
            cmd.used_sub = 1'b1;
            cmd.ld_rel   = 1'b1;
            if (count_r == '0) begin
              j_nxt = '0; state_nxt = S_FDEC;
            end else begin
              cmd.fm_re = 1'b1;
              state_nxt = S_FSCAN;
            end
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_RSCAN: begin
        if (sts.hit) begin
          cmd.ld_cur = 1'b1;
          j_nxt      = Cw'(ra_r);
          state_nxt  = S_RSPL;
        end else if (ra_inc < count_r) begin
          cmd.fm_re = 1'b1;
          fm_raddr  = Aw'(ra_inc);
          ra_nxt    = Aw'(ra_inc);
        end else begin
          st_nxt = ST_NO_FIT; state_nxt = S_DONE;
        end
      end
      S_RSPL: begin
        cmd.id_we    = 1'b1;
        cmd.used_add = 1'b1;
        cmd.res_rsv  = 1'b1;
        st_nxt       = ST_OK;
        if (sts.cur_gt) begin
          cmd.fm_we = 1'b1;
          cmd.wsel  = WS_SPLIT;
          fm_waddr  = Aw'(j_r);
          state_nxt = S_DONE;
        end else if (j_r + Cw'(1) < count_r) begin
          cmd.fm_re = 1'b1;
          fm_raddr  = Aw'(j_r + Cw'(1));
          ra_nxt    = Aw'(j_r + Cw'(1));
          state_nxt = S_SHDN;
        end else begin
          count_nxt = count_r - Cw'(1);
          state_nxt = S_DONE;
        end
      end
      S_SHDN: begin
        cmd.fm_we = 1'b1;
        cmd.wsel  = WS_COPY;
        fm_waddr  = ra_r - Aw'(1);
        if (ra_inc < count_r) begin
          cmd.fm_re = 1'b1;
          fm_raddr  = Aw'(ra_inc);
          ra_nxt    = Aw'(ra_inc);
        end else begin
          count_nxt = count_r - Cw'(1);
          state_nxt = S_DONE;
        end
      end
      S_FSCAN: begin
        if (sts.q_lt_o) begin
          cmd.ld_prev = 1'b1;
          if (ra_inc < count_r) begin
            cmd.fm_re = 1'b1;
            fm_raddr  = Aw'(ra_inc);
            ra_nxt    = Aw'(ra_inc);
          end else begin
            j_nxt     = count_r;
            state_nxt = S_FDEC;
          end
        end else begin
          cmd.ld_cur = 1'b1;
          j_nxt      = Cw'(ra_r);
          state_nxt  = S_FDEC;
        end
      end
      S_FDEC: begin
        if (sts.after && sts.prev_abut) begin
          cmd.acc_ld = 1'b1;
          state_nxt  = S_FBOTH;
        end else if (sts.prev_abut) begin
          cmd.fm_we = 1'b1;
          cmd.wsel  = WS_BEFORE;
          fm_waddr  = Aw'(j_r - Cw'(1));
          state_nxt = S_DONE;
        end else if (sts.after) begin
          cmd.fm_we = 1'b1;
          cmd.wsel  = WS_AFTER;
          fm_waddr  = Aw'(j_r);
          state_nxt = S_DONE;
        end else if (count_r < Cw'(Depth)) begin
          if (j_r < count_r) begin
            cmd.fm_re = 1'b1;
            fm_raddr  = Aw'(count_r - Cw'(1));
            ra_nxt    = Aw'(count_r - Cw'(1));
            state_nxt = S_SHUP;
          end else begin
            state_nxt = S_INS;
          end
        end else begin
          // list full: drop the segment
          state_nxt = S_DONE;
        end
      end
      S_FBOTH: begin
        cmd.fm_we = 1'b1;
        cmd.wsel  = WS_BOTH;
        fm_waddr  = Aw'(j_r - Cw'(1));
        if (j_r + Cw'(1) < count_r) begin
          cmd.fm_re = 1'b1;
          fm_raddr  = Aw'(j_r + Cw'(1));
          ra_nxt    = Aw'(j_r + Cw'(1));
          state_nxt = S_SHDN;
        end else begin
          count_nxt = count_r - Cw'(1);
          state_nxt = S_DONE;
        end
      end
      S_SHUP: begin
        cmd.fm_we = 1'b1;
        cmd.wsel  = WS_COPY;
        fm_waddr  = Aw'(ra_inc);
        if (Cw'(ra_r) > j_r) begin
          cmd.fm_re = 1'b1;
          fm_raddr  = ra_r - Aw'(1);
          ra_nxt    = ra_r - Aw'(1);
        end else begin
          state_nxt = S_INS;
        end
      end
      S_INS: begin
        cmd.fm_we = 1'b1;
        cmd.wsel  = WS_INS;
        fm_waddr  = Aw'(j_r);
        count_nxt = count_r + Cw'(1);
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!ov_r || out_ready) begin
          cmd.out_ld = 1'b1;
          ov_nxt     = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    // a capacity write always rebuilds the free list
    if (cap_wr) pend_nxt = 1'b1;
  end

  // Hold controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ra_r    <= '0;
      j_r     <= '0;
      count_r <= '0;
      st_r    <= ST_OK;
      pend_r  <= 1'b1;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ra_r    <= ra_nxt;
      j_r     <= j_nxt;
      count_r <= count_nxt;
      st_r    <= st_nxt;
      pend_r  <= pend_nxt;
      ov_r    <= ov_nxt;
    end
  end

endmodule

@@ rtl/core/ffca_dp.sv @@
module ffca_dp #(
  parameter int MaxIds = 64,
  parameter int Aw = 7
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [1:0]      in_kind,
  input  logic [5:0]      in_slot_id,
  input  logic [31:0]     in_request_size,
  input  logic [31:0]     capacity,
  input  logic [4:0]      align_log2,
  input  ffca_pkg::cmd_t  cmd,
  input  logic [Aw-1:0]   fm_raddr,
  input  logic [Aw-1:0]   fm_waddr,
  input  logic [1:0]      st_code,
  output ffca_pkg::sts_t  sts,
  output logic [1:0]      out_status,
  output logic [31:0]     out_slot_offset,
  output logic [31:0]     out_slot_size,
  output logic [31:0]     out_slot_cap,
  output logic [31:0]     out_used_total
);
  import ffca_pkg::*;

  localparam int Depth = MaxIds + 1;
  localparam int Iw  = (MaxIds > 1) ? $clog2(MaxIds) : 1;
  localparam int Idw = (Iw > 6) ? Iw : 6;

  // Free list and slot tables
  logic [31:0] fm_off  [Depth];
  logic [31:0] fm_size [Depth];
  logic [31:0] id_off_m  [MaxIds];
  logic [31:0] id_size_m [MaxIds];
  logic [31:0] id_cap_m  [MaxIds];
  logic [MaxIds-1:0] id_vld_r;

  logic [1:0]  kind_r;
  logic [5:0]  slot_r;
  logic [31:0] size_r, cap_r;
  logic        ovf_r;
  logic [31:0] q_off_r, q_size_r;
  logic [31:0] id_off_q, id_size_q, id_cap_q;
  logic [31:0] cur_off_r, cur_size_r, prev_off_r, prev_size_r;
  logic        cur_v_r, prev_v_r;
  logic [31:0] rel_o_r, rel_c_r, acc_r, used_r;
  logic [31:0] res_off_r, res_size_r, res_cap_r;
  logic [1:0]  o_st_r;
  logic [31:0] o_off_r, o_size_r, o_cap_r, o_used_r;

  logic [Idw-1:0] in_ext, slot_ext;
  logic [Iw-1:0]  in_idx, slot_idx;
  logic [32:0]    mask, cap_sum;
  logic [31:0]    w_off, w_size;
  logic [32:0]    end33, prev_end33;

  assign in_ext   = Idw'(in_slot_id);
  assign slot_ext = Idw'(slot_r);
  assign in_idx   = in_ext[Iw-1:0];
  assign slot_idx = slot_ext[Iw-1:0];

  // Round the request up to the alignment
  assign mask    = (33'd1 << align_log2) - 33'd1;
  assign cap_sum = ({1'b0, in_request_size} + mask) & ~mask;

  assign end33      = {1'b0, rel_o_r} + {1'b0, rel_c_r};
  assign prev_end33 = {1'b0, prev_off_r} + {1'b0, prev_size_r};

  assign sts.kind      = kind_r;
  assign sts.in_range  = 32'(slot_r) < 32'(MaxIds);
  assign sts.id_used   = id_vld_r[slot_idx];
  assign sts.cap_ovf   = ovf_r;
  assign sts.hit       = q_size_r >= cap_r;
  assign sts.cur_gt    = cur_size_r > cap_r;
  assign sts.q_lt_o    = q_off_r < rel_o_r;
  assign sts.after     = cur_v_r && ({1'b0, cur_off_r} == end33);
  assign sts.prev_abut = prev_v_r && (prev_end33 == {1'b0, rel_o_r});

  // Select free-list write data
  always_comb begin
    case (cmd.wsel)
      WS_INIT:   begin w_off = '0;                  w_size = capacity; end
      WS_SPLIT:  begin w_off = cur_off_r + cap_r;   w_size = cur_size_r - cap_r; end
      WS_COPY:   begin w_off = q_off_r;             w_size = q_size_r; end
      WS_BEFORE: begin w_off = prev_off_r;          w_size = sat_add(prev_size_r, rel_c_r); end
      WS_BOTH:   begin w_off = prev_off_r;          w_size = sat_add(acc_r, cur_size_r); end
      WS_AFTER:  begin w_off = rel_o_r;             w_size = sat_add(cur_size_r, rel_c_r); end
      default:   begin w_off = rel_o_r;             w_size = rel_c_r; end
    endcase
  end

  // Free-list memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.fm_we) begin
      fm_off[fm_waddr]  <= w_off;
      fm_size[fm_waddr] <= w_size;
    end
    if (cmd.fm_re) begin
      q_off_r  <= fm_off[fm_raddr];
      q_size_r <= fm_size[fm_raddr];
    end
  end

  // Slot tables, read on transfer of a request
  always_ff @(posedge clk) begin
    if (cmd.id_we) begin
      id_off_m[slot_idx]  <= cur_off_r;
      id_size_m[slot_idx] <= size_r;
      id_cap_m[slot_idx]  <= cap_r;
    end
    if (cmd.ld_item) begin
      id_off_q  <= id_off_m[in_idx];
      id_size_q <= id_size_m[in_idx];
      id_cap_q  <= id_cap_m[in_idx];
    end
  end

  // Slot valid bits and used byte count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_vld_r <= '0;
      used_r   <= '0;
    end else begin
      if (cmd.id_we)   id_vld_r[slot_idx] <= 1'b1;
      if (cmd.vld_clr) id_vld_r[slot_idx] <= 1'b0;
      if (cmd.used_add) used_r <= used_r + cap_r;
      if (cmd.used_sub) used_r <= used_r - id_cap_q;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.ld_item) begin
      kind_r <= in_kind;
      slot_r <= in_slot_id;
      size_r <= in_request_size;
      cap_r  <= cap_sum[31:0];
      ovf_r  <= cap_sum[32];
    end
    if (cmd.ld_rel) begin
      rel_o_r <= id_off_q;
      rel_c_r <= id_cap_q;
    end
    if (cmd.acc_ld) acc_r <= sat_add(prev_size_r, rel_c_r);
    if (cmd.ld_prev) begin
      prev_off_r  <= q_off_r;
      prev_size_r <= q_size_r;
    end
    if (cmd.ld_cur) begin
      cur_off_r  <= q_off_r;
      cur_size_r <= q_size_r;
    end
    if (cmd.res_id) begin
      res_off_r  <= id_off_q;
      res_size_r <= id_size_q;
      res_cap_r  <= id_cap_q;
    end else if (cmd.res_rsv) begin
      res_off_r  <= cur_off_r;
      res_size_r <= size_r;
      res_cap_r  <= cap_r;
    end else if (cmd.res_clr) begin
      res_off_r  <= '0;
      res_size_r <= '0;
      res_cap_r  <= '0;
    end
    if (cmd.out_ld) begin
      o_st_r   <= st_code;
      o_off_r  <= res_off_r;
      o_size_r <= res_size_r;
      o_cap_r  <= res_cap_r;
      o_used_r <= used_r;
    end
  end

  // Neighbour flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r  <= 1'b0;
      prev_v_r <= 1'b0;
    end else if (cmd.clr_pc) begin
      cur_v_r  <= 1'b0;
      prev_v_r <= 1'b0;
    end else begin
      if (cmd.ld_cur)  cur_v_r  <= 1'b1;
      if (cmd.ld_prev) prev_v_r <= 1'b1;
    end
  end

  assign out_status      = o_st_r;
  assign out_slot_offset = o_off_r;
  assign out_slot_size   = o_size_r;
  assign out_slot_cap    = o_cap_r;
  assign out_used_total  = o_used_r;

endmodule

@@ rtl/core/first_fit_coalescing_allocator_top.sv @@
// First-fit buffer suballocator with free-segment coalescing.
// Input channel (in_*): kind 0 reserves request_size bytes for slot_id, kind 1
// frees the slot, kind 2 or 3 looks it up. Each request gives one result on
// the out_* channel: status, slot offset/size/capacity and the used byte total.
// Requests are handled one at a time. A lookup or failed check goes from
// the dispatch state straight to the done state, which loads the output
// register; a reserve or free walks the free list held in a memory one entry
// per cycle, then shifts entries on insert or removal before it reaches the
// done state, then returns to idle. in_ready is high only while idle.
// The next request is taken while a finished result still waits in the
// output register; if the receiver stalls, the following result holds in the
// block until the register frees.
// Reset (synchronous, rst_n low) frees all slots, clears the used total and
// sets capacity 65536, alignment 2^8. A write of buffer_capacity over the APB
// port rebuilds the free list as one segment; this happens in the idle state
// before the next request is taken, and slots keep their records.
module first_fit_coalescing_allocator_top #(
  parameter int MAX_IDS = ffca_pkg::MAX_IDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [5:0]  in_slot_id,
  input  logic [31:0] in_request_size,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [31:0] out_slot_offset,
  output logic [31:0] out_slot_size,
  output logic [31:0] out_slot_cap,
  output logic [31:0] out_used_total,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import ffca_pkg::*;

  localparam int Depth = MAX_IDS + 1;
  localparam int Aw = $clog2(Depth);
  localparam int Cw = $clog2(Depth + 1);

  logic [31:0] cap_r;
  logic [4:0]  align_r;
  logic        wr_en, cap_wr;
  cmd_t        cmd;
  sts_t        sts;
  logic [Aw-1:0] fm_raddr, fm_waddr;
  logic [1:0]  st_code;

  // Register file: write on the access phase
  assign cfg_pready = 1'b1;
  assign wr_en  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cap_wr = wr_en && (cfg_paddr[2] == REG_CAPACITY);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= CAPACITY_RST;
      align_r <= ALIGN_RST;
    end else if (wr_en) begin
      if (cfg_paddr[2] == REG_CAPACITY) cap_r <= cfg_pwdata;
      else                              align_r <= cfg_pwdata[4:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_ALIGN) ? {27'd0, align_r} : cap_r;

  ffca_ctrl #(.MaxIds(MAX_IDS), .Aw(Aw), .Cw(Cw)) u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
    .cap_wr, .sts, .cmd, .fm_raddr, .fm_waddr, .st_code
  );

  ffca_dp #(.MaxIds(MAX_IDS), .Aw(Aw)) u_dp (
    .clk, .rst_n, .in_kind, .in_slot_id, .in_request_size,
    .capacity(cap_r), .align_log2(align_r), .cmd, .fm_raddr, .fm_waddr,
    .st_code, .sts, .out_status, .out_slot_offset, .out_slot_size,
    .out_slot_cap, .out_used_total
  );

`include "first_fit_coalescing_allocator_top_assert.svh"

  `FFCA_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "request taken while busy")
  `FFCA_ASSERT_NEXT(a_result_shown, cmd.out_ld, out_valid, "result load lost")
  `FFCA_ASSERT_NEXT(a_rebuild_first, cap_wr, !in_ready, "request taken before list rebuild")
  `FFCA_ASSERT_NOW(a_no_overwrite, cmd.out_ld, !out_valid || out_ready, "result overwritten")

endmodule

@@ dv/tb_first_fit_coalescing_allocator_top.sv @@
module tb_first_fit_coalescing_allocator_top;
  import ffca_pkg::*;

  localparam int NUM_IDS = 64;
  localparam int SEG_DEPTH = NUM_IDS + 1;
  localparam logic [1:0] K_LOOKUP = 2'd2;
  localparam logic [1:0] K_ODD = 2'd3;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] offset;
    logic [31:0] size;
    logic [31:0] capacity;
    logic [31:0] used;
  } alloc_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_kind = '0;
  logic [5:0]  in_slot_id = '0;
  logic [31:0] in_request_size = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic [31:0] out_slot_offset;
  logic [31:0] out_slot_size;
  logic [31:0] out_slot_cap;
  logic [31:0] out_used_total;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  first_fit_coalescing_allocator_top dut (.*);

  always #5 clk = ~clk;

  // Allocator shadow state
  logic [31:0] cap_reg;
  logic [4:0]  align_reg;
  logic [31:0] seg_off [SEG_DEPTH];
  logic [31:0] seg_len [SEG_DEPTH];
  int          seg_cnt;
  logic        slot_live [NUM_IDS];
  logic [31:0] slot_off [NUM_IDS];
  logic [31:0] slot_len [NUM_IDS];
  logic [31:0] slot_cap [NUM_IDS];
  logic [31:0] used_bytes;

  alloc_result_t pending_results[$];
  int  error_count = 0;
  bit  stall_enable = 1'b1;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    error_count++;
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
  endtask

  function automatic logic [31:0] sat32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic void rebuild_free_list();
    for (int i = 0; i < SEG_DEPTH; i++) begin
      seg_off[i] = '0;
      seg_len[i] = '0;
    end
    seg_len[0] = cap_reg;
    seg_cnt = 1;
  endfunction

  function automatic void drop_segment(input int j);
    for (int k = j; k + 1 < seg_cnt; k++) begin
      seg_off[k] = seg_off[k + 1];
      seg_len[k] = seg_len[k + 1];
    end
    seg_cnt--;
  endfunction

  function automatic logic [1:0] claim_slot(input int id, input logic [31:0] req);
    logic [32:0] mask;
    logic [32:0] rounded;
    logic [31:0] cap;
    int i;
    mask = (33'd1 << align_reg) - 33'd1;
    rounded = ({1'b0, req} + mask) & ~mask;
    if (slot_live[id]) return ST_IN_USE;
    if (rounded[32]) return ST_NO_FIT;
    cap = rounded[31:0];
    for (i = 0; i < seg_cnt; i++)
      if (seg_len[i] >= cap) break;
    if (i >= seg_cnt) return ST_NO_FIT;
    slot_off[id] = seg_off[i];
    slot_len[id] = req;
    slot_cap[id] = cap;
    slot_live[id] = 1'b1;
    if (seg_len[i] > cap) begin
      seg_off[i] = seg_off[i] + cap;
      seg_len[i] = seg_len[i] - cap;
    end else begin
      drop_segment(i);
    end
    used_bytes = used_bytes + cap;
    return ST_OK;
  endfunction

  function automatic void return_segment(input logic [31:0] o, input logic [31:0] c);
    int j;
    logic [32:0] seg_end;
    bit after_hit, before_hit;
    j = 0;
    seg_end = {1'b0, o} + {1'b0, c};
    while (j < seg_cnt && seg_off[j] < o) j++;
    after_hit = j < seg_cnt && {1'b0, seg_off[j]} == seg_end;
    before_hit = j > 0 && ({1'b0, seg_off[j-1]} + {1'b0, seg_len[j-1]}) == {1'b0, o};
    if (after_hit && before_hit) begin
      seg_len[j-1] = sat32(sat32(seg_len[j-1], c), seg_len[j]);
      drop_segment(j);
    end else if (before_hit) begin
      seg_len[j-1] = sat32(seg_len[j-1], c);
    end else if (after_hit) begin
      seg_off[j] = o;
      seg_len[j] = sat32(seg_len[j], c);
    end else if (seg_cnt < SEG_DEPTH) begin
      for (int k = seg_cnt; k > j; k--) begin
        seg_off[k] = seg_off[k-1];
        seg_len[k] = seg_len[k-1];
      end
      seg_off[j] = o;
      seg_len[j] = c;
      seg_cnt++;
    end
  endfunction

  function automatic alloc_result_t predict_allocation(input logic [1:0] kind, input int id,
                                                       input logic [31:0] req);
    alloc_result_t r;
    r = '0;
    if (kind == K_RESERVE) begin
      r.status = claim_slot(id, req);
    end else if (!slot_live[id]) begin
      r.status = ST_NOT_FOUND;
    end else begin
      r.status = ST_OK;
      if (kind == K_FREE) begin
        r.offset = slot_off[id];
        r.size = slot_len[id];
        r.capacity = slot_cap[id];
        slot_live[id] = 1'b0;
        used_bytes = used_bytes - slot_cap[id];
        return_segment(slot_off[id], slot_cap[id]);
      end
    end
    if (r.status == ST_OK && kind != K_FREE) begin
      r.offset = slot_off[id];
      r.size = slot_len[id];
      r.capacity = slot_cap[id];
    end
    r.used = used_bytes;
    return r;
  endfunction

  // Send one request; hold valid over bursts, drop it in random gaps
  task automatic send_request(input logic [1:0] kind, input int id, input logic [31:0] req);
    if ($urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_slot_id <= id[5:0];
    in_request_size <= req;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_allocation(kind, id, req));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (idx == REG_CAPACITY) begin
      cap_reg = value;
      rebuild_free_list();
    end else begin
      align_reg = value[4:0];
    end
    repeat (2) @(posedge clk);
  endtask

  // Receiver stalls on its own pattern
  always @(posedge clk) begin
    if (!stall_enable) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 3) != 0);
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    alloc_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report("unexpected result", {30'd0, out_status}, '0);
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) report("status", {30'd0, out_status}, {30'd0, want.status});
        if (out_slot_offset !== want.offset) report("slot_offset", out_slot_offset, want.offset);
        if (out_slot_size !== want.size) report("slot_size", out_slot_size, want.size);
        if (out_slot_cap !== want.capacity)
          report("slot_cap", out_slot_cap, want.capacity);
        if (out_used_total !== want.used) report("used_total", out_used_total, want.used);
      end
    end
  end

  // Field extremes, all kinds, in-use, overflow and zero-size cases
  task automatic test_directed();
    send_request(K_LOOKUP, 0, 32'd0);
    send_request(K_FREE, 63, 32'hFFFF_FFFF);
    send_request(K_RESERVE, 0, 32'd0);
    send_request(K_RESERVE, 1, 32'd1);
    send_request(K_RESERVE, 1, 32'd5);
    send_request(K_RESERVE, 63, 32'hFFFF_FFFF);
    send_request(K_RESERVE, 2, 32'h0001_0000);
    send_request(K_RESERVE, 3, 32'd300);
    send_request(K_ODD, 3, 32'd0);
    send_request(K_LOOKUP, 63, 32'hAAAA_5555);
    send_request(K_FREE, 1, 32'd0);
    send_request(K_FREE, 3, 32'd0);
    send_request(K_FREE, 0, 32'd0);
    send_request(K_RESERVE, 4, 32'd65536);
    send_request(K_RESERVE, 5, 32'd256);
    send_request(K_FREE, 4, 32'd0);
    send_request(K_FREE, 4, 32'd0);
    wait_drained();
  endtask

  // Huge capacity and alignment extremes, with a merge up to the full capacity
  task automatic test_register_extremes();
    write_register(REG_ALIGN, 32'd16);
    write_register(REG_CAPACITY, 32'hFFFF_FFFF);
    send_request(K_RESERVE, 10, 32'hFFFF_0000);
    send_request(K_RESERVE, 11, 32'hFFFF_0001);
    send_request(K_RESERVE, 12, 32'd1);
    send_request(K_FREE, 10, 32'd0);
    wait_drained();
    write_register(REG_ALIGN, 32'd0);
    write_register(REG_CAPACITY, 32'd0);
    send_request(K_RESERVE, 13, 32'd0);
    send_request(K_RESERVE, 14, 32'd1);
    send_request(K_FREE, 13, 32'd0);
    wait_drained();
  endtask

  // Many small slots so the free list fills and fragments
  task automatic test_fragmentation(input int count);
    int id;
    int pick;
    for (int n = 0; n < count; n++) begin
      id = $urandom_range(0, NUM_IDS - 1);
      pick = $urandom_range(0, 9);
      if (pick < 5)
        send_request(K_RESERVE, id, (pick == 0) ? $urandom() : $urandom_range(0, 40));
      else if (pick < 9)
        send_request(K_FREE, id, $urandom());
      else
        send_request(2'($urandom_range(2, 3)), id, $urandom());
    end
    wait_drained();
  endtask

  // Random sizes at mixed alignments
  task automatic test_random_mix(input int count);
    int id;
    logic [1:0] kind;
    logic [31:0] req;
    for (int n = 0; n < count; n++) begin
      id = $urandom_range(0, NUM_IDS - 1);
      kind = 2'($urandom_range(0, 3));
      case ($urandom_range(0, 3))
        0: req = $urandom();
        1: req = $urandom_range(0, 4096);
        2: req = 32'hFFFF_FFFF - $urandom_range(0, 300);
        default: req = $urandom_range(0, cap_reg >> 3);
      endcase
      send_request(kind, id, req);
    end
  endtask

  initial begin
    cap_reg = CAPACITY_RST;
    align_reg = ALIGN_RST;
    rebuild_free_list();
    for (int i = 0; i < NUM_IDS; i++) begin
      slot_live[i] = 1'b0;
      slot_off[i] = '0;
      slot_len[i] = '0;
      slot_cap[i] = '0;
    end
    used_bytes = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_register_extremes();
    write_register(REG_ALIGN, 32'd0);
    write_register(REG_CAPACITY, 32'd4000);
    test_fragmentation(400);
    write_register(REG_ALIGN, 32'd4);
    write_register(REG_CAPACITY, 32'h8000_0000);
    test_random_mix(400);
    stall_enable = 1'b0;
    test_random_mix(200);
    wait_drained();
    stall_enable = 1'b1;
    write_register(REG_ALIGN, 32'd9);
    write_register(REG_CAPACITY, 32'd1 << 20);
    test_random_mix(300);
    wait_drained();
    write_register(REG_ALIGN, 32'd1);
    write_register(REG_CAPACITY, 32'd700);
    test_fragmentation(330);

    if (error_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  initial begin
    #6000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
